// File: design/assert_macros.svh
// Assertion helpers shared by the design files.
// Each expects signals named clock and reset in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define VGE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define VGE_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: design/vge_pkg.sv
package vge_pkg;

   localparam int NODE_W     = 16;
   localparam int GREY_W     = 8;
   localparam int SIZE_W     = 17;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 3;
   localparam int WIDE_W     = 2 * SIZE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam int NODE_CAPACITY_DEF = 65536;
   localparam int QUEUE_DEPTH_DEF   = 2;

   localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LIST  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

   localparam logic [STAT_W-1:0] ST_EDGE    = 3'd0;
   localparam logic [STAT_W-1:0] ST_NONE    = 3'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 3'd2;
   localparam logic [STAT_W-1:0] ST_ADJ     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_ADJ = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
   localparam logic [SIZE_W-1:0] SIZE_X_RST = 17'd256;
   localparam logic [SIZE_W-1:0] SIZE_Y_RST = 17'd256;
   localparam logic [SIZE_W-1:0] SIZE_Z_RST = 17'd1;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] other;
      logic [GREY_W-1:0] grey;
   } item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] sx;
      logic [SIZE_W-1:0] sy;
      logic [SIZE_W-1:0] sz;
   } grid_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > SIZE_MAX) r = SIZE_MAX;
      return r;
   endfunction

endpackage

// File: design/vge_front.sv
// Take request beats, drop the unused action code, hand the rest to the queue.
module vge_front import vge_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACT_W-1:0]      req_tuser,
   output logic                  push,
   output item_type              item,
   input  logic                  full
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_tready = !valid_ff || !full;
   assign take       = req_tvalid && req_tready;
   assign push       = valid_ff && !full;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push) valid_in = 1'b0;
      if (take) valid_in = (req_tuser != ACT_NOP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.action <= req_tuser;
         item_ff.node   <= req_tdata[NODE_W-1:0];
         item_ff.other  <= req_tdata[2*NODE_W-1:NODE_W];
         item_ff.grey   <= req_tdata[2*NODE_W+GREY_W-1:2*NODE_W];
      end
   end

endmodule

// File: design/vge_fifo.sv
`include "assert_macros.svh"
// Short item queue between front and back.
module vge_fifo import vge_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type din,
   output logic     full,
   input  logic     pop,
   output item_type dout,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        slots [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign dout  = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (push && !pop) count_in = count_ff + CW'(1);
      if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots[wr_ptr_ff] <= din;
   end

   `VGE_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "queue count beyond depth")
   `VGE_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
   `VGE_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")

endmodule

// File: design/vge_div.sv
// Restoring divider: one quotient bit per cycle.
module vge_div import vge_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NODE_W-1:0] dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [NODE_W-1:0] quot,
   output logic [NODE_W-1:0] rem
);

   localparam int CNT_W = $clog2(NODE_W);

   logic              busy_ff, done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [NODE_W-1:0] dvd_ff;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] dsr_ff;
   logic [SIZE_W:0]   sh;
   logic              ge;

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff[NODE_W-1:0];

   always_comb begin
      sh     = {rem_ff, dvd_ff[NODE_W-1]};
      ge     = (sh >= {1'b0, dsr_ff});
      rem_in = ge ? SIZE_W'(sh - {1'b0, dsr_ff}) : sh[SIZE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NODE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[NODE_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

endmodule

// File: design/vge_back.sv
`include "assert_macros.svh"
// Sequencer: range check, grey writes, coordinate split, grey reads, adjacency test and result beats.
module vge_back import vge_pkg::*; #(
   parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  grid_type              grid,
   input  logic                  q_empty,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STAT_W-1:0]     rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int AW = $clog2(NODE_CAPACITY);
   localparam logic [WIDE_W-1:0] CAP_WIDE = WIDE_W'(NODE_CAPACITY);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LIM1 = 4'd1;
   localparam logic [3:0] S_LIM2 = 4'd2;
   localparam logic [3:0] S_CHK  = 4'd3;
   localparam logic [3:0] S_DXS  = 4'd4;
   localparam logic [3:0] S_DXW  = 4'd5;
   localparam logic [3:0] S_DYS  = 4'd6;
   localparam logic [3:0] S_DYW  = 4'd7;
   localparam logic [3:0] S_MASK = 4'd8;
   localparam logic [3:0] S_RDN  = 4'd9;
   localparam logic [3:0] S_GN   = 4'd10;
   localparam logic [3:0] S_RDO  = 4'd11;
   localparam logic [3:0] S_EDGE = 4'd12;
   localparam logic [3:0] S_ONE  = 4'd13;
   localparam logic [3:0] S_TEST = 4'd14;

   logic [3:0]        state_ff, state_in;
   item_type          item_ff;
   logic              second_ff;
   logic [WIDE_W-1:0] sxy_ff, tot_ff;
   logic              big_ff;
   logic [NODE_W-1:0] q_ff, x_ff, y_ff, z_ff, ux_ff, uy_ff, uz_ff;
   logic [5:0]        mask_ff;
   logic [WIDE_W-1:0] nb_ff [6];
   logic [GREY_W-1:0] grey_n_ff, rd_data_ff;
   logic [NODE_W-1:0] one_lo_ff, one_hi_ff;
   logic [STAT_W-1:0] one_st_ff;

   logic              out_valid_ff, out_last_ff;
   logic [NODE_W-1:0] out_lo_ff, out_hi_ff;
   logic [GREY_W-1:0] out_w_ff;
   logic [STAT_W-1:0] out_st_ff;
   logic              load_out, out_free;
   logic [NODE_W-1:0] out_lo_in, out_hi_in;
   logic [GREY_W-1:0] out_w_in;
   logic [STAT_W-1:0] out_st_in;
   logic              out_last_in;

   logic [GREY_W-1:0] mem [NODE_CAPACITY];
   logic              mem_we;
   logic [AW-1:0]     rd_addr;

   logic [WIDE_W-1:0] mul_xy, mul_t, n_w, m_w, other_w;
   logic              n_ok, m_ok;
   logic [5:0]        mask_calc, remaining;
   logic [WIDE_W-1:0] nb_calc [6];
   logic [2:0]        sel;
   logic              below, w_ok, adj, edges_left;
   logic [GREY_W-1:0] diff;
   logic [NODE_W-1:0] dx, dy, dz;

   logic              div_start, div_busy, div_done;
   logic [NODE_W-1:0] div_dvd, div_quot, div_rem;
   logic [SIZE_W-1:0] div_dsr;

   assign mul_xy = grid.sx * grid.sy;
   assign mul_t  = sxy_ff[NODE_W-1:0] * grid.sz;
   assign n_w    = WIDE_W'(item_ff.node);
   assign m_w    = WIDE_W'(item_ff.other);
   assign n_ok   = (big_ff || n_w < tot_ff) && n_w < CAP_WIDE;
   assign m_ok   = (big_ff || m_w < tot_ff) && m_w < CAP_WIDE;
   assign q_pop  = (state_ff == S_IDLE) && !q_empty;
   assign mem_we = (state_ff == S_CHK) && (item_ff.action == ACT_WRITE) && n_ok;

   assign div_start = (state_ff == S_DXS) || (state_ff == S_DYS);
   assign div_dvd   = (state_ff == S_DYS) ? q_ff : (second_ff ? item_ff.other : item_ff.node);
   assign div_dsr   = (state_ff == S_DYS) ? grid.sy : grid.sx;

   vge_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Neighbor indices and presence, in emission order
   always_comb begin
      nb_calc[0]   = n_w - sxy_ff;
      nb_calc[1]   = n_w - WIDE_W'(grid.sx);
      nb_calc[2]   = n_w - WIDE_W'(1);
      nb_calc[3]   = n_w + WIDE_W'(1);
      nb_calc[4]   = n_w + WIDE_W'(grid.sx);
      nb_calc[5]   = n_w + sxy_ff;
      mask_calc[0] = (z_ff != '0);
      mask_calc[1] = (y_ff != '0);
      mask_calc[2] = (x_ff != '0);
      mask_calc[3] = (SIZE_W'(x_ff) != grid.sx - SIZE_W'(1));
      mask_calc[4] = (SIZE_W'(y_ff) != grid.sy - SIZE_W'(1));
      mask_calc[5] = (SIZE_W'(z_ff) != grid.sz - SIZE_W'(1));
   end

   // Lowest pending edge
   always_comb begin
      sel = 3'd0;
      for (int i = 5; i >= 0; i--) begin
         if (mask_ff[i]) sel = 3'(i);
      end
   end

   always_comb begin
      other_w    = nb_ff[sel];
      below      = (sel < 3'd3);
      w_ok       = (other_w < CAP_WIDE);
      diff       = (grey_n_ff > rd_data_ff) ? grey_n_ff - rd_data_ff : rd_data_ff - grey_n_ff;
      remaining  = mask_ff & ~(6'b1 << sel);
      edges_left = (remaining != '0);
      dx  = (ux_ff > x_ff) ? ux_ff - x_ff : x_ff - ux_ff;
      dy  = (uy_ff > y_ff) ? uy_ff - y_ff : y_ff - uy_ff;
      dz  = (uz_ff > z_ff) ? uz_ff - z_ff : z_ff - uz_ff;
      adj = (dx == NODE_W'(1) && dy == '0 && dz == '0) ||
            (dx == '0 && dy == NODE_W'(1) && dz == '0) ||
            (dx == '0 && dy == '0 && dz == NODE_W'(1));
   end

   always_comb begin
      unique case (state_ff)
         S_RDN:                  rd_addr = n_w[AW-1:0];
         S_GN, S_RDO, S_EDGE:    rd_addr = other_w[AW-1:0];
         default:                rd_addr = n_w[AW-1:0];
      endcase
   end

   // Result beat selection
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      load_out    = 1'b0;
      out_lo_in   = one_lo_ff;
      out_hi_in   = one_hi_ff;
      out_w_in    = '0;
      out_st_in   = one_st_ff;
      out_last_in = 1'b1;
      unique case (state_ff)
         S_ONE: begin
            load_out = out_free;
         end
         S_EDGE: begin
            load_out    = out_free;
            out_lo_in   = below ? other_w[NODE_W-1:0] : item_ff.node;
            out_hi_in   = below ? item_ff.node : other_w[NODE_W-1:0];
            out_w_in    = w_ok ? diff : '0;
            out_st_in   = ST_EDGE;
            out_last_in = !edges_left;
         end
         S_TEST: begin
            load_out  = out_free;
            out_lo_in = (item_ff.node < item_ff.other) ? item_ff.node : item_ff.other;
            out_hi_in = (item_ff.node < item_ff.other) ? item_ff.other : item_ff.node;
            out_st_in = adj ? ST_ADJ : ST_NOT_ADJ;
         end
         default: begin
            load_out = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (!q_empty) state_in = S_LIM1;
         S_LIM1: state_in = S_LIM2;
         S_LIM2: state_in = S_CHK;
         S_CHK: begin
            unique case (item_ff.action)
               ACT_WRITE: state_in = n_ok ? S_IDLE : S_ONE;
               ACT_LIST:  state_in = n_ok ? S_DXS : S_ONE;
               ACT_TEST:  state_in = (n_ok && m_ok) ? S_DXS : S_ONE;
               default:   state_in = S_IDLE;
            endcase
         end
         S_DXS: state_in = S_DXW;
         S_DXW: if (div_done) state_in = S_DYS;
         S_DYS: state_in = S_DYW;
         S_DYW: begin
            if (div_done) begin
               if (item_ff.action == ACT_TEST) state_in = second_ff ? S_TEST : S_DXS;
               else state_in = S_MASK;
            end
         end
         S_MASK: state_in = (mask_calc == '0) ? S_ONE : S_RDN;
         S_RDN:  state_in = S_GN;
         S_GN:   state_in = S_EDGE;
         S_RDO:  state_in = S_EDGE;
         S_EDGE: if (load_out) state_in = edges_left ? S_RDO : S_IDLE;
         S_ONE:  if (load_out) state_in = S_IDLE;
         S_TEST: if (load_out) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            item_ff   <= q_item;
            second_ff <= 1'b0;
         end
         S_LIM1: sxy_ff <= mul_xy;
         S_LIM2: begin
            tot_ff <= mul_t;
            big_ff <= |sxy_ff[WIDE_W-1:NODE_W];
         end
         S_CHK: begin
            one_lo_ff <= '0;
            one_hi_ff <= '0;
            one_st_ff <= ST_RANGE;
         end
         S_DXW: begin
            if (div_done) begin
               x_ff <= div_rem;
               q_ff <= div_quot;
            end
         end
         S_DYW: begin
            if (div_done) begin
               y_ff <= div_rem;
               z_ff <= div_quot;
               if (!second_ff) begin
                  ux_ff <= x_ff;
                  uy_ff <= div_rem;
                  uz_ff <= div_quot;
               end
               second_ff <= 1'b1;
            end
         end
         S_MASK: begin
            mask_ff <= mask_calc;
            for (int i = 0; i < 6; i++) nb_ff[i] <= nb_calc[i];
            one_lo_ff <= item_ff.node;
            one_hi_ff <= item_ff.node;
            one_st_ff <= ST_NONE;
         end
         S_GN:   grey_n_ff <= rd_data_ff;
         S_EDGE: if (load_out) mask_ff <= remaining;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_lo_ff   <= out_lo_in;
         out_hi_ff   <= out_hi_in;
         out_w_ff    <= out_w_in;
         out_st_ff   <= out_st_in;
         out_last_ff <= out_last_in;
      end
   end

   // Grey store
   always_ff @(posedge clock) begin
      if (mem_we) mem[n_w[AW-1:0]] <= item_ff.grey;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_w_ff, out_hi_ff, out_lo_ff};
   assign rsp_tuser  = out_st_ff;
   assign rsp_tlast  = out_last_ff;

   `VGE_ASSERT(a_div_idle_start, div_start |-> !div_busy, "divider restarted while busy")
   `VGE_ASSERT_NEXT(a_write_done, mem_we, state_ff == S_IDLE, "write did not retire")
   `VGE_ASSERT(a_partial_list, (out_valid_ff && !out_last_ff) |-> (state_ff == S_EDGE || state_ff == S_RDO), "non-final edge beat outside edge list")

endmodule

// File: design/voxel_grid_edge_generator.sv
// Each node index is split into coordinates by two bit-per-cycle divisions, then one grey read
// is made per edge. Only one item is in the back at a time; a two-beat queue and the front
// register let the input run ahead.
// Reset (sync, active high) clears control state, sets 256x256x1; grey store stays unwritten.
module voxel_grid_edge_generator import vge_pkg::*; #(
   parameter int NODE_CAPACITY = NODE_CAPACITY_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // node, other_node, grey
   input  logic [ACT_W-1:0]      req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // low_node, high_node, weight
   output logic [STAT_W-1:0]     rsp_tuser,  // status
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   // Grid sizes, held already clamped to 1..65536
   logic [SIZE_W-1:0] size_x_ff, size_x_in;
   logic [SIZE_W-1:0] size_y_ff, size_y_in;
   logic [SIZE_W-1:0] size_z_ff, size_z_in;
   grid_type          grid;

   logic     push, full, pop, empty;
   item_type front_item, queue_item;

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_in = clamp_size(csr_wdata);
            CSR_SIZE_Y: size_y_in = clamp_size(csr_wdata);
            CSR_SIZE_Z: size_z_in = clamp_size(csr_wdata);
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_X_RST;
         size_y_ff <= SIZE_Y_RST;
         size_z_ff <= SIZE_Z_RST;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   assign grid.sx = size_x_ff;
   assign grid.sy = size_y_ff;
   assign grid.sz = size_z_ff;

   // Front: accept beats and drop the unused action code
   vge_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .item       (front_item),
      .full       (full)
   );

   // Queue decoupling front and back
   vge_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_item),
      .full  (full),
      .pop   (pop),
      .dout  (queue_item),
      .empty (empty)
   );

   // Back: range check, coordinates, grey store and result register
   vge_back #(
      .NODE_CAPACITY (NODE_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .grid       (grid),
      .q_empty    (empty),
      .q_item     (queue_item),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/sv/voxel_grid_edge_generator_test.sv
module voxel_grid_edge_generator_test;
   import vge_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 120;    // longest item is a test

   // Expected beats for the grid, kept against a private copy of sizes and grey values
   class edge_scoreboard;
      typedef struct {
         logic [NODE_W-1:0] low;
         logic [NODE_W-1:0] high;
         logic [GREY_W-1:0] weight;
         logic [STAT_W-1:0] status;
         logic              last;
      } edge_beat;

      edge_beat           beats_q[$];
      logic [GREY_W-1:0]  shade [NODE_CAPACITY_DEF];
      longint unsigned    sx, sy, sz, limit;
      int                 errors;

      function new();
         sx = 256; sy = 256; sz = 1; limit = 65536; errors = 0;
      endfunction

      function void set_size(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
         longint unsigned v;
         v = val;
         if (v == 0) v = 1;
         else if (v > 65536) v = 65536;
         if (idx == CSR_SIZE_X) sx = v;
         else if (idx == CSR_SIZE_Y) sy = v;
         else if (idx == CSR_SIZE_Z) sz = v;
         limit = sx * sy * sz;
         if (limit > NODE_CAPACITY_DEF) limit = NODE_CAPACITY_DEF;
      endfunction

      function void push(longint unsigned lo, longint unsigned hi, int w,
                         logic [STAT_W-1:0] st, logic lst);
         edge_beat b;
         b.low = lo[NODE_W-1:0]; b.high = hi[NODE_W-1:0];
         b.weight = w[GREY_W-1:0]; b.status = st; b.last = lst;
         beats_q.insert(beats_q.size(), b);
      endfunction

      function void split(longint unsigned n, output longint unsigned x,
                          output longint unsigned y, output longint unsigned z);
         x = n % sx;
         y = (n / sx) % sy;
         z = n / (sx * sy);
      endfunction

      function void note(logic [ACT_W-1:0] act, logic [NODE_W-1:0] n,
                         logic [NODE_W-1:0] m, logic [GREY_W-1:0] g);
         longint unsigned x, y, z, vx, vy, vz, d, sxy;
         longint unsigned lo [6];
         longint unsigned hi [6];
         int k, w;
         sxy = sx * sy;
         k = 0;
         case (act)
            ACT_WRITE: begin
               if (n >= limit) push(0, 0, 0, ST_RANGE, 1);
               else shade[n] = g;
            end
            ACT_LIST: begin
               if (n >= limit) begin
                  push(0, 0, 0, ST_RANGE, 1);
               end else begin
                  split(n, x, y, z);
                  if (z != 0)      begin lo[k] = n - sxy; hi[k] = n; k++; end
                  if (y != 0)      begin lo[k] = n - sx;  hi[k] = n; k++; end
                  if (x != 0)      begin lo[k] = n - 1;   hi[k] = n; k++; end
                  if (x != sx - 1) begin lo[k] = n; hi[k] = n + 1;   k++; end
                  if (y != sy - 1) begin lo[k] = n; hi[k] = n + sx;  k++; end
                  if (z != sz - 1) begin lo[k] = n; hi[k] = n + sxy; k++; end
                  if (k == 0) push(n, n, 0, ST_NONE, 1);
                  for (int i = 0; i < k; i++) begin
                     w = 0;
                     // an upper neighbour past the capacity carries no weight
                     if (lo[i] < limit && hi[i] < limit) begin
                        w = int'(shade[lo[i]]) - int'(shade[hi[i]]);
                        if (w < 0) w = -w;
                     end
                     push(lo[i], hi[i], w, ST_EDGE, i == k - 1);
                  end
               end
            end
            ACT_TEST: begin
               if (n >= limit || m >= limit) begin
                  push(0, 0, 0, ST_RANGE, 1);
               end else begin
                  split(n, x, y, z);
                  split(m, vx, vy, vz);
                  d = (x > vx ? x - vx : vx - x) + (y > vy ? y - vy : vy - y)
                      + (z > vz ? z - vz : vz - z);
                  push(n < m ? n : m, n < m ? m : n, 0,
                       d == 1 ? ST_ADJ : ST_NOT_ADJ, 1);
               end
            end
            default: ;    // unused code: dropped by the block
         endcase
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check(logic [NODE_W-1:0] low, logic [NODE_W-1:0] high,
                 logic [GREY_W-1:0] w, logic [STAT_W-1:0] st, logic lst);
         edge_beat e;
         if (beats_q.size() == 0) begin
            report($sformatf("unexpected beat low=%0d high=%0d status=%0d", low, high, st));
            return;
         end
         e = beats_q.pop_front();
         if (low !== e.low)
            report($sformatf("low_node %0d, expected %0d", low, e.low));
         if (high !== e.high)
            report($sformatf("high_node %0d, expected %0d", high, e.high));
         if (w !== e.weight)
            report($sformatf("weight %0d, expected %0d (edge %0d-%0d)", w, e.weight,
                             e.low, e.high));
         if (st !== e.status)
            report($sformatf("status %0d, expected %0d", st, e.status));
         if (lst !== e.last)
            report($sformatf("last %0b, expected %0b", lst, e.last));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // node, other_node, grey
   logic [ACT_W-1:0]      req_tuser = '0;   // action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // low_node, high_node, weight
   logic [STAT_W-1:0]     rsp_tuser;        // status
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [SIZE_W-1:0]     csr_wdata = '0;

   edge_scoreboard sb = new();
   bit             written [NODE_CAPACITY_DEF];  // voxels with a defined grey value
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             hold_cycles = 0;
   int             cycle_count = 0;

   voxel_grid_edge_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Receiver: a long hold-off is counted down here, otherwise stall at random
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check every accepted result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check(rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[39:32], rsp_tuser,
                  rsp_tlast);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("voxel_grid_edge_generator test failed");
         $finish;
      end
   end

   // Offer one beat, idling first at random; leave tvalid high after acceptance
   // so back-to-back beats never lower and raise it in one step.
   task automatic send_beat(logic [ACT_W-1:0] act, logic [NODE_W-1:0] n,
                            logic [NODE_W-1:0] m, logic [GREY_W-1:0] g);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {g, m, n};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(act, n, m, g);
      if (act == ACT_WRITE && n < sb.limit) written[n] = 1'b1;
   endtask

   task automatic write_voxel(longint unsigned n);
      send_beat(ACT_WRITE, n[NODE_W-1:0], 16'($urandom), 8'($urandom));
   endtask

   // Give the node and every voxel one step away a grey value before listing
   task automatic list_node(longint unsigned n);
      longint signed c;
      longint signed offs [6];
      offs = '{0, 1, -1, 0, 0, 0};
      offs[3] = sb.sx; offs[4] = -longint'(sb.sx); offs[5] = sb.sx * sb.sy;
      if (n < sb.limit) begin
         for (int i = 0; i < 7; i++) begin
            c = (i == 6) ? longint'(n) - longint'(sb.sx * sb.sy) : longint'(n) + offs[i];
            if (c >= 0 && c < longint'(sb.limit) && !written[c]) write_voxel(c);
         end
      end
      send_beat(ACT_LIST, n[NODE_W-1:0], 16'($urandom), 8'($urandom));
   endtask

   // Drop tvalid and hold until every expected beat has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.beats_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_grid(logic [SIZE_W-1:0] x, logic [SIZE_W-1:0] y,
                           logic [SIZE_W-1:0] z);
      logic [SIZE_W-1:0] vals [3];
      vals = '{x, y, z};
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_size(CSR_IDX_W'(i), vals[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic longint unsigned pick_node();
      if ($urandom_range(9) == 0) return $urandom_range(65535);
      return $urandom_range(int'(sb.limit) - 1);
   endfunction

   // Mostly real neighbours so adjacency is hit, else anything
   function automatic longint unsigned pick_partner(longint unsigned n);
      longint signed c;
      case ($urandom_range(7))
         0: c = longint'(n) + 1;
         1: c = longint'(n) - 1;
         2: c = longint'(n) + longint'(sb.sx);
         3: c = longint'(n) - longint'(sb.sx);
         4: c = longint'(n) + longint'(sb.sx * sb.sy);
         5: c = longint'(n) - longint'(sb.sx * sb.sy);
         default: c = pick_node();
      endcase
      if (c < 0 || c > 65535) c = pick_node();
      return c;
   endfunction

   task automatic random_items(int count);
      longint unsigned n;
      int sel;
      for (int i = 0; i < count; i++) begin
         n = pick_node();
         sel = $urandom_range(99);
         if (sel < 30) write_voxel(n);
         else if (sel < 68) list_node(n);
         else if (sel < 95)
            send_beat(ACT_TEST, n[NODE_W-1:0], 16'(pick_partner(n)), 8'($urandom));
         else send_beat(ACT_NOP, 16'($urandom), 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int idle_modes [4][2];
      logic [SIZE_W-1:0] grids [7][3];
      idle_modes = '{'{0, 0}, '{55, 0}, '{0, 55}, '{36, 36}};
      grids = '{'{17'd4, 17'd3, 17'd2}, '{17'd131071, 17'd1, 17'd1},
                '{17'd65536, 17'd2, 17'd1}, '{17'd5, 17'd7, 17'd3},
                '{17'd2, 17'd2, 17'd2}, '{17'd1, 17'd65536, 17'd1},
                '{17'd256, 17'd256, 17'd1}};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset grid corners, grey extremes, adjacency both ways, unused code
      send_beat(ACT_WRITE, 16'd0, 16'hFFFF, 8'd0);
      send_beat(ACT_WRITE, 16'd1, 16'h0000, 8'd255);
      send_beat(ACT_WRITE, 16'd256, 16'hFFFF, 8'd128);
      list_node(0);
      list_node(65535);
      send_beat(ACT_TEST, 16'd0, 16'd256, 8'hFF);
      send_beat(ACT_TEST, 16'd65535, 16'd0, 8'h00);
      send_beat(ACT_TEST, 16'd255, 16'd256, 8'h00);
      send_beat(ACT_NOP, 16'hFFFF, 16'hFFFF, 8'hFF);

      // Zero sizes: a single voxel, everything else out of range
      set_grid('0, '0, '0);
      send_beat(ACT_WRITE, 16'd5, 16'd0, 8'd9);
      send_beat(ACT_WRITE, 16'd0, 16'd0, 8'd77);
      list_node(0);
      list_node(1);
      send_beat(ACT_TEST, 16'd0, 16'd0, 8'd0);
      send_beat(ACT_TEST, 16'd0, 16'hFFFF, 8'd0);
      send_beat(ACT_TEST, 16'hFFFF, 16'd0, 8'd0);

      // Small 3-D grid: upper-z face, one node past the end, adjacency across z and a row wrap
      set_grid(17'd4, 17'd3, 17'd2);
      list_node(17);
      list_node(23);
      list_node(24);
      send_beat(ACT_TEST, 16'd5, 16'd17, 8'd0);
      send_beat(ACT_TEST, 16'd3, 16'd4, 8'd0);

      // Random phases across grids and idle patterns
      for (int p = 0; p < 7; p++) begin
         set_grid(grids[p][0], grids[p][1], grids[p][2]);
         send_idle_pct  = idle_modes[p % 4][0];
         recv_stall_pct = idle_modes[p % 4][1];
         if (p == 3) begin
            // long receiver hold-off while the sender keeps offering
            send_idle_pct = 0;
            hold_cycles   = 400;
            random_items(12);
            // then pause the sender until every result is back
            drain();
            send_idle_pct = idle_modes[3][0];
            random_items(12);
         end else begin
            random_items(24);
         end
         if (p == 1 || p == 5) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            random_items(8);
         end
      end

      drain();
      if (sb.errors == 0) begin
         $display("voxel_grid_edge_generator test passed");
      end else begin
         $display("voxel_grid_edge_generator test failed");
      end
      $finish;
   end

endmodule
